@@ rtl/core/pcc_pkg.sv @@
// pcc_pkg: shared types and constants of the pcm channel converter
// item structs, config struct, sequencer states and register indexes; no dependencies

package pcc_pkg;

  localparam int unsigned MaxChannelsDef = 8;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned CfgRegW        = 4;
  localparam int unsigned ApbAddrW       = 3;
  localparam int unsigned ApbDataW       = 32;

  localparam logic RegInChannels  = 1'b0;
  localparam logic RegOutChannels = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CfgRegW-1:0] in_channels;
    logic [CfgRegW-1:0] out_channels;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ONE,
    ST_COPY
  } pcc_state_e;

endpackage

@@ rtl/core/pcc_apb_regs.sv @@
// pcc_apb_regs: apb configuration registers (in_channels, out_channels)
// depends on pcc_pkg

module pcc_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]    pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  output pcc_pkg::cfg_t                   cfg_o
);
  import pcc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == RegOutChannels) begin
        cfg_d.out_channels = pwdata[CfgRegW-1:0];
      end else begin
        cfg_d.in_channels = pwdata[CfgRegW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_channels  <= CfgRegW'(1);
      cfg_q.out_channels <= CfgRegW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    if (paddr[2] == RegOutChannels) begin
      prdata = {{(ApbDataW-CfgRegW){1'b0}}, cfg_q.out_channels};
    end else begin
      prdata = {{(ApbDataW-CfgRegW){1'b0}}, cfg_q.in_channels};
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pcc_divider.sv @@
// pcc_divider: bit-serial signed divide of the frame sum by the channel count
// one quotient bit per cycle, truncates toward zero; depends on pcc_pkg

module pcc_divider #(
  parameter int unsigned MAX_CHANNELS = pcc_pkg::MaxChannelsDef
) (
  input  logic                                                      clk_i,
  input  logic                                                      rst_ni,
  input  logic                                                      start_i,
  input  logic signed [pcc_pkg::SampleW+$clog2(MAX_CHANNELS)-1:0]   dividend_i,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]                         divisor_i,
  output logic                                                      done_o,
  output logic signed [pcc_pkg::SampleW-1:0]                        quotient_o
);
  import pcc_pkg::*;

  localparam int unsigned SumW  = SampleW + $clog2(MAX_CHANNELS);
  localparam int unsigned CntW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned StepW = $clog2(SumW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic             neg_q, neg_d;
  logic [SumW-1:0]  dvd_q, dvd_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;

  logic [SumW-1:0]  mag;
  logic [CntW:0]    trial;
  logic [CntW:0]    diff;
  logic             ge;
  logic [SumW-1:0]  quo_signed;

  assign mag   = dividend_i[SumW-1] ? (~dividend_i + SumW'(1)) : dividend_i;
  assign trial = {rem_q, dvd_q[SumW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW - 1);
      neg_d  = dividend_i[SumW-1];
      dvd_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[SumW-2:0], ge};
      rem_d  = ge ? diff[CntW-1:0] : trial[CntW-1:0];
      step_d = step_q - StepW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quo_signed = neg_q ? (~dvd_q + SumW'(1)) : dvd_q;
  assign quotient_o = quo_signed[SampleW-1:0];
  assign done_o     = done_q;

endmodule

@@ rtl/core/pcm_channel_converter.sv @@
// pcm_channel_converter: top level, frame tracking, result sequencer and output register
// depends on pcc_pkg, pcc_apb_regs, pcc_divider

// Interleaved 16-bit PCM samples enter one item at a time and are grouped into frames of
// in_channels samples; frames of out_channels samples leave. Equal counts pass each sample
// through, one output channel gives the frame average truncated toward zero, otherwise
// output channel c copies input channel min(c, in_channels-1). stream_end drops a partial
// frame. An item is taken while the sequencer is idle, and the block is then busy until its
// last result is loaded into the output register: an item with no result leaves it idle,
// a pass-through loads one result, a frame copy reads one frame store entry per cycle
// while the output is not stalled, and an average first waits for the bit-serial divider.
// A stalled output holds the block busy longer. Channel registers of 0 act as 1 and
// values above MAX_CHANNELS act as MAX_CHANNELS.

module pcm_channel_converter #(
  parameter int unsigned MAX_CHANNELS = pcc_pkg::MaxChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pcc_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pcc_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]  pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import pcc_pkg::*;

  localparam int unsigned SumW = SampleW + $clog2(MAX_CHANNELS);
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned PosW = $clog2(MAX_CHANNELS);

  cfg_t cfg;

  pcc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective channel counts
  logic [CntW-1:0] nin, nout;

  function automatic logic [CntW-1:0] eff_count(input logic [CfgRegW-1:0] r);
    logic [CfgRegW:0] ext;
    logic [CfgRegW:0] lim;
    logic [CfgRegW:0] v;
    ext = {1'b0, r};
    lim = (CfgRegW+1)'(MAX_CHANNELS);
    if (ext == '0) begin
      v = (CfgRegW+1)'(1);
    end else if (ext > lim) begin
      v = lim;
    end else begin
      v = ext;
    end
    return v[CntW-1:0];
  endfunction

  assign nin  = eff_count(cfg.in_channels);
  assign nout = eff_count(cfg.out_channels);

  pcc_state_e state_q, state_d;

  logic [SampleW-1:0]      store_q [MAX_CHANNELS];
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [PosW-1:0]         chan_q, chan_d;
  logic [SampleW-1:0]      one_val_q, one_val_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;

  logic                    accept;
  logic                    slot_free;
  logic                    load_out;
  logic                    div_start;
  logic                    div_done;
  logic signed [SampleW-1:0] div_quot;
  logic [CntW-1:0]         pos_inc;
  logic                    frame_done;
  logic signed [SumW-1:0]  sum_new;
  logic [PosW-1:0]         src;
  logic                    copy_last;

  assign accept     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign pos_inc    = CntW'(pos_q) + CntW'(1);
  assign frame_done = pos_inc >= nin;
  assign sum_new    = sum_q + {{(SumW-SampleW){in_item_i.sample[SampleW-1]}}, in_item_i.sample};
  assign src        = (CntW'(chan_q) < nin) ? chan_q : PosW'(nin - CntW'(1));
  assign copy_last  = (CntW'(chan_q) + CntW'(1)) == nout;

  pcc_divider #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (nin),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (nin == nout) begin
            state_d = ST_ONE;
          end else if (frame_done) begin
            state_d = (nout == CntW'(1)) ? ST_DIV : ST_COPY;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ONE;
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (slot_free && copy_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    div_start  = 1'b0;
    out_item_d = out_item_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i && (nin != nout) && frame_done && (nout == CntW'(1));
      end
      ST_DIV: begin
      end
      ST_ONE: begin
        load_out = slot_free;
        if (slot_free) begin
          out_item_d.sample_out  = one_val_q;
          out_item_d.last_of_run = 1'b1;
        end
      end
      ST_COPY: begin
        load_out = slot_free;
        if (slot_free) begin
          out_item_d.sample_out  = store_q[src];
          out_item_d.last_of_run = copy_last;
        end
      end
      default: begin
      end
    endcase
  end

  // frame tracking and result data
  always_comb begin
    sum_d     = sum_q;
    pos_d     = pos_q;
    chan_d    = chan_q;
    one_val_d = one_val_q;
    if (accept) begin
      one_val_d = in_item_i.sample;
      chan_d    = '0;
      if (frame_done || in_item_i.stream_end) begin
        sum_d = '0;
        pos_d = '0;
      end else begin
        sum_d = sum_new;
        pos_d = pos_inc[PosW-1:0];
      end
    end else if (state_q == ST_DIV && div_done) begin
      one_val_d = div_quot;
    end else if (state_q == ST_COPY && load_out) begin
      chan_d = chan_q + PosW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      pos_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    one_val_q  <= one_val_d;
    out_item_q <= out_item_d;
    if (accept) begin
      store_q[pos_q] <= in_item_i.sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY |-> CntW'(chan_q) < nout)
    else $error("copy channel beyond out_channels");

  a_pass_goes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (nin == nout) |=> state_q == ST_ONE)
    else $error("equal counts item did not go to single result");

  a_pos_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(pos_q) < CntW'(MAX_CHANNELS))
    else $error("frame position beyond frame store");

  a_avg_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_DIV)
    else $error("average item did not enter divide state");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the pcm channel converter
// drives sample items and apb register writes, predicts every output frame and compares it
// depends on pcc_pkg and pcm_channel_converter

class channel_conv_board;
  logic [pcc_pkg::CfgRegW-1:0] in_reg;
  logic [pcc_pkg::CfgRegW-1:0] out_reg;
  logic signed [pcc_pkg::SampleW-1:0] frame_store [pcc_pkg::MaxChannelsDef];
  int frame_sum;
  int frame_pos;
  pcc_pkg::out_item_t pending_out [$];
  int unsigned mismatches;

  function new();
    in_reg = 1;
    out_reg = 1;
    frame_sum = 0;
    frame_pos = 0;
    mismatches = 0;
    foreach (frame_store[i]) frame_store[i] = '0;
  endfunction

  function void set_channels(logic idx, logic [pcc_pkg::CfgRegW-1:0] value);
    if (idx == pcc_pkg::RegInChannels) begin
      in_reg = value;
    end else begin
      out_reg = value;
    end
  endfunction

  // 0 acts as 1, anything above the maximum acts as the maximum
  function int span(logic [pcc_pkg::CfgRegW-1:0] value);
    if (value == 0) return 1;
    if (value > pcc_pkg::MaxChannelsDef) return int'(pcc_pkg::MaxChannelsDef);
    return int'(value);
  endfunction

  function void take_sample(pcc_pkg::in_item_t item);
    int nin;
    int nout;
    int p;
    int src;
    nin = span(in_reg);
    nout = span(out_reg);
    p = frame_pos;
    if (p >= int'(pcc_pkg::MaxChannelsDef)) p = int'(pcc_pkg::MaxChannelsDef) - 1;
    frame_store[p] = item.sample;
    frame_sum = frame_sum + $signed(item.sample);
    if (nin == nout) begin
      pending_out.push_back(pcc_pkg::out_item_t'{sample_out: item.sample, last_of_run: 1'b1});
    end
    if (p + 1 >= nin) begin
      if (nin != nout) begin
        if (nout == 1) begin
          pending_out.push_back(pcc_pkg::out_item_t'{
            sample_out: pcc_pkg::SampleW'(frame_sum / nin), last_of_run: 1'b1});
        end else begin
          for (int c = 0; c < nout; c++) begin
            src = (c < nin) ? c : nin - 1;
            pending_out.push_back(pcc_pkg::out_item_t'{
              sample_out: frame_store[src], last_of_run: (c == nout - 1)});
          end
        end
      end
      frame_sum = 0;
      frame_pos = 0;
    end else begin
      frame_pos = p + 1;
    end
    if (item.stream_end) begin
      frame_sum = 0;
      frame_pos = 0;
    end
  endfunction

  function void check_sample(pcc_pkg::out_item_t got);
    pcc_pkg::out_item_t want;
    if (pending_out.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected output item: sample %0d last %0b", got.sample_out,
                 got.last_of_run);
      end
      return;
    end
    want = pending_out.pop_front();
    if (got.sample_out !== want.sample_out || got.last_of_run !== want.last_of_run) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("output differs: expected sample %0d last %0b, got sample %0d last %0b",
                 want.sample_out, want.last_of_run, got.sample_out, got.last_of_run);
      end
    end
  endfunction
endclass

module tb_top;
  import pcc_pkg::*;

  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseItems   = 40;
  localparam int unsigned Phases       = 10;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bit                calm_send = 1'b0;
  bit                calm_recv = 1'b0;
  int unsigned       idle_cycles = 0;
  channel_conv_board board = new();

  pcm_channel_converter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SampleW'($urandom_range(0, 15) - 8);
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_channels();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
  endfunction

  task automatic send_item(logic signed [SampleW-1:0] value, bit last);
    in_item_t    item;
    int unsigned gap;
    item = in_item_t'{sample: value, stream_end: last};
    gap = pause_len(calm_send);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    board.take_sample(item);
  endtask

  // stop sending, let every expected item drain and the block go quiet
  task automatic hold_input();
    in_valid_i <= 1'b0;
    while (board.pending_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgRegW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    board.set_channels(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned in_cfg, int unsigned out_cfg);
    hold_input();
    write_reg(RegInChannels, CfgRegW'(in_cfg));
    write_reg(RegOutChannels, CfgRegW'(out_cfg));
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pause_len(calm_recv);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      board.check_sample(out_item_o);
    end
  end

  initial begin : stimulus
    int unsigned in_cfg;
    int unsigned out_cfg;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through at reset counts
    send_item(32767, 1'b0);
    send_item(-32768, 1'b0);
    // zero and oversized registers: repeat one sample to eight outputs
    set_config(0, 15);
    send_item(32767, 1'b0);
    send_item(-32768, 1'b1);
    // average, truncation toward zero, stream end dropping a partial frame
    set_config(3, 1);
    send_item(-1, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(5, 1'b0);
    send_item(7, 1'b1);
    send_item(-32768, 1'b0);
    send_item(-32768, 1'b0);
    send_item(-32768, 1'b0);
    // eight-channel downmix to two
    set_config(15, 2);
    for (int i = 0; i < 8; i++) send_item(i[0] ? -32768 : 32767, 1'b0);
    // upmix with last input channel repeated, then counts changed inside a frame
    set_config(2, 5);
    send_item(100, 1'b0);
    send_item(-200, 1'b0);
    send_item(1, 1'b0);
    set_config(1, 3);
    send_item(9, 1'b0);

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin in_cfg = 8; out_cfg = 8; end
        1: begin in_cfg = 8; out_cfg = 1; end
        2: begin in_cfg = 1; out_cfg = 8; end
        3: begin in_cfg = 6; out_cfg = 0; end
        default: begin
          in_cfg = pick_channels();
          out_cfg = pick_channels();
        end
      endcase
      set_config(in_cfg, out_cfg);
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 5 && i == PhaseItems / 2) hold_input();
        send_item(pick_sample(), $urandom_range(0, 11) == 0);
      end
    end

    hold_input();
    if (board.mismatches == 0 && board.pending_out.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ pcm_channel_converter.f @@
rtl/core/pcc_pkg.sv
rtl/core/pcc_apb_regs.sv
rtl/core/pcc_divider.sv
rtl/core/pcm_channel_converter.sv
tb/tb_top.sv
